>>> rtl/core/aqnc_pkg.sv
// Shared types, character codes and classification functions of the unquoted-atom classifier.
`default_nettype none
package aqnc_pkg;

    localparam int CHAR_W = 8;

    typedef logic [CHAR_W-1:0] t_char;

    typedef enum logic [3:0] {
        MODE_START  = 4'd0,
        MODE_LBRACK = 4'd1,
        MODE_LBRACE = 4'd2,
        MODE_SOLO   = 4'd3,
        MODE_PAIR   = 4'd4,
        MODE_DOT    = 4'd5,
        MODE_WORD   = 4'd6,
        MODE_SYMBOL = 4'd7,
        MODE_DEAD   = 4'd8
    } t_mode;

    localparam t_char CH_LBRACK = 8'h5B;  // [
    localparam t_char CH_RBRACK = 8'h5D;  // ]
    localparam t_char CH_LBRACE = 8'h7B;  // {
    localparam t_char CH_RBRACE = 8'h7D;  // }
    localparam t_char CH_SEMI   = 8'h3B;  // ;
    localparam t_char CH_BANG   = 8'h21;  // !
    localparam t_char CH_DOT    = 8'h2E;  // .
    localparam t_char CH_BAR    = 8'h7C;  // |
    localparam t_char CH_UNDER  = 8'h5F;  // _
    localparam t_char CH_LC_A   = 8'h61;
    localparam t_char CH_LC_Z   = 8'h7A;
    localparam t_char CH_UC_A   = 8'h41;
    localparam t_char CH_UC_Z   = 8'h5A;
    localparam t_char CH_DIG_0  = 8'h30;
    localparam t_char CH_DIG_9  = 8'h39;

    function automatic logic is_lower(input t_char c);
        return (c >= CH_LC_A) && (c <= CH_LC_Z);
    endfunction

    function automatic logic is_word_char(input t_char c);
        return is_lower(c) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
               ((c >= CH_DIG_0) && (c <= CH_DIG_9)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_symbol_char(input t_char c, input logic bar_ok);
        logic sym;
        unique case (c)
            8'h23, 8'h24, 8'h26, 8'h2A, 8'h2B, 8'h2D,  // # $ & * + -
            8'h2E, 8'h2F, 8'h3A, 8'h3C, 8'h3D, 8'h3E,  // . / : < = >
            8'h3F, 8'h40, 8'h5E, 8'h7E, 8'h5C:         // ? @ ^ ~ backslash
                sym = 1'b1;
            CH_BAR:
                sym = bar_ok;
            default:
                sym = 1'b0;
        endcase
        return sym;
    endfunction

    function automatic t_mode next_mode(input t_mode mode, input t_char c,
                                        input logic bar_ok);
        t_mode nm;
        unique case (mode)
            MODE_START: begin
                priority if (c == CH_LBRACK)                 nm = MODE_LBRACK;
                else if (c == CH_LBRACE)                     nm = MODE_LBRACE;
                else if ((c == CH_SEMI) || (c == CH_BANG))   nm = MODE_SOLO;
                else if (c == CH_DOT)                        nm = MODE_DOT;
                else if (is_lower(c))                        nm = MODE_WORD;
                else if (is_symbol_char(c, bar_ok))          nm = MODE_SYMBOL;
                else                                         nm = MODE_DEAD;
            end
            MODE_LBRACK: nm = (c == CH_RBRACK) ? MODE_PAIR : MODE_DEAD;
            MODE_LBRACE: nm = (c == CH_RBRACE) ? MODE_PAIR : MODE_DEAD;
            MODE_DOT, MODE_SYMBOL:
                nm = is_symbol_char(c, bar_ok) ? MODE_SYMBOL : MODE_DEAD;
            MODE_WORD:   nm = is_word_char(c) ? MODE_WORD : MODE_DEAD;
            default:     nm = MODE_DEAD;
        endcase
        return nm;
    endfunction

    function automatic logic mode_is_safe(input t_mode mode);
        return (mode == MODE_SOLO) || (mode == MODE_PAIR) ||
               (mode == MODE_WORD) || (mode == MODE_SYMBOL);
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/aqnc_in_if.sv
// Input channel of the classifier: one byte of an atom name per beat.
`default_nettype none
interface aqnc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    logic       empty_name;
    logic       allow_bar;

    modport source (output valid, output char_code, output is_last,
                    output empty_name, output allow_bar, input ready);
    modport sink   (input valid, input char_code, input is_last,
                    input empty_name, input allow_bar, output ready);
endinterface
`default_nettype wire

>>> rtl/core/aqnc_out_if.sv
// Result channel of the classifier: one verdict per name.
`default_nettype none
interface aqnc_out_if;
    logic valid;
    logic ready;
    logic is_safe;

    modport source (output valid, output is_safe, input ready);
    modport sink   (input valid, input is_safe, output ready);
endinterface
`default_nettype wire

>>> rtl/core/atom_quote_need_classifier_unit.sv
// Top level of the unquoted-atom classifier.
`default_nettype none
// Takes an atom name one byte per beat (empty_name marks a beat without a byte,
// is_last closes the name) and returns one is_safe beat per name: 1 when the
// name may be written without quotes. A beat can be taken every cycle; the
// beat is captured in an input register and classified against the running
// scan mode as it leaves that register, and the verdict of a closing beat then
// lands in the output register. A full output register holds up the input
// only while a closing beat waits for it; other beats keep flowing.
module atom_quote_need_classifier_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    aqnc_in_if.sink          i_in,
    aqnc_out_if.source       o_out
);
    import aqnc_pkg::*;

    logic  r_s1_valid;
    t_char r_s1_char;
    logic  r_s1_last;
    logic  r_s1_empty;
    logic  r_s1_bar;

    t_mode r_mode;
    logic  r_out_valid;
    logic  r_out_safe;

    t_mode n_mode_step;
    logic  s1_adv;
    logic  in_fire;

    assign n_mode_step = r_s1_empty ? r_mode
                                    : next_mode(r_mode, r_s1_char, r_s1_bar);

    // A beat that closes a name needs the output register free.
    assign s1_adv  = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_char  <= i_in.char_code;
            r_s1_last  <= i_in.is_last;
            r_s1_empty <= i_in.empty_name;
            r_s1_bar   <= i_in.allow_bar;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
        end else if (s1_adv) begin
            r_mode <= r_s1_last ? MODE_START : n_mode_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_safe <= mode_is_safe(n_mode_step);
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.is_safe = r_out_safe;

    // A new verdict appears only from a closing beat leaving the input register.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(s1_adv && r_s1_last))
        else $error("verdict appeared without a closing beat");

    // Every name starts its scan from a clean mode.
    a_mode_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(s1_adv && r_s1_last) |-> (r_mode == MODE_START))
        else $error("scan mode not restarted after a name");

    // A pending verdict that is not taken never loses its closing beat.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_s1_valid && r_s1_last) |-> !s1_adv)
        else $error("closing beat advanced over a pending verdict");

endmodule
`default_nettype wire

>>> bench/aqnc_verdict_checker.sv
// Checker for the unquoted-atom classifier: tracks the scan mode per name and compares verdicts.
`timescale 1ns / 1ps
module aqnc_verdict_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    aqnc_in_if   i_beat_mon,
    aqnc_out_if  i_verdict_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import aqnc_pkg::*;

    t_mode scan_state;
    logic  verdict_q[$];

    function automatic logic glyph_is_symbol(input t_char c, input logic bar_ok);
        logic hit;
        case (c)
            "#", "$", "&", "*", "+", "-", ".", "/", ":",
            "<", "=", ">", "?", "@", "^", "~", "\\": hit = 1'b1;
            CH_BAR:                                 hit = bar_ok;
            default:                                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic glyph_is_word(input t_char c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
               (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_UNDER);
    endfunction

    function automatic t_mode advance_scan(input t_mode m, input t_char c,
                                           input logic bar_ok);
        t_mode r;
        r = MODE_DEAD;
        case (m)
            MODE_START: begin
                if (c == CH_LBRACK)                        r = MODE_LBRACK;
                else if (c == CH_LBRACE)                   r = MODE_LBRACE;
                else if (c == CH_SEMI || c == CH_BANG)     r = MODE_SOLO;
                else if (c == CH_DOT)                      r = MODE_DOT;
                else if (c >= CH_LC_A && c <= CH_LC_Z)     r = MODE_WORD;
                else if (glyph_is_symbol(c, bar_ok))       r = MODE_SYMBOL;
            end
            MODE_LBRACK: if (c == CH_RBRACK) r = MODE_PAIR;
            MODE_LBRACE: if (c == CH_RBRACE) r = MODE_PAIR;
            MODE_DOT, MODE_SYMBOL: if (glyph_is_symbol(c, bar_ok)) r = MODE_SYMBOL;
            MODE_WORD:   if (glyph_is_word(c)) r = MODE_WORD;
            default:     r = MODE_DEAD;
        endcase
        return r;
    endfunction

    // A lone dot and an unfinished bracket pair both end in an unsafe mode.
    function automatic logic name_is_bare(input t_mode m);
        return (m == MODE_SOLO) || (m == MODE_PAIR) ||
               (m == MODE_WORD) || (m == MODE_SYMBOL);
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            scan_state = MODE_START;
            verdict_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_verdict_mon.valid && i_verdict_mon.ready) begin
                if (verdict_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: verdict beat is_safe=%0b with no name pending",
                                 $time, i_verdict_mon.is_safe);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_verdict_mon.is_safe !== want) begin
                        if (o_fail_count < 10)
                            $display("%0t: is_safe mismatch, expected %0b, got %0b",
                                     $time, want, i_verdict_mon.is_safe);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_beat_mon.valid && i_beat_mon.ready) begin
                if (!i_beat_mon.empty_name)
                    scan_state = advance_scan(scan_state, i_beat_mon.char_code,
                                              i_beat_mon.allow_bar);
                if (i_beat_mon.is_last) begin
                    verdict_q = {verdict_q, name_is_bare(scan_state)};
                    scan_state = MODE_START;
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

>>> bench/tb_atom_quote_need_classifier_unit.sv
// Testbench top for the unquoted-atom classifier: clock, reset, name stimulus and verdict.
`timescale 1ns / 1ps
module tb_atom_quote_need_classifier_unit;
    import aqnc_pkg::*;

    localparam int BEAT_TARGET = 400;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_char code;
        logic  last;
        logic  blank;
        logic  bar;
    } t_beat;

    logic  i_clk;
    logic  i_rst_n;
    int    fail_count;
    int    pending;
    int    cycle_count;
    int    beat_count;
    int    name_count;
    bit    tx_gappy;
    bit    scatter_blanks;
    bit    hold_req;
    int    burst_left;
    t_beat name_beats[$];
    string sym_set   = "#$&*+-./:<=>?@^~\\|";
    string mixed_set = "[]{};!.az_Z09|#~ ";

    aqnc_in_if  in_ch ();
    aqnc_out_if out_ch ();

    atom_quote_need_classifier_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    aqnc_verdict_checker verdict_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat_mon    (in_ch),
        .i_verdict_mon (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("atom_quote_need_classifier_unit test failed");
            $finish;
        end
    end

    function automatic void push_blank();
        t_beat b;
        b.code  = t_char'($urandom_range(0, 255));
        b.last  = 1'b0;
        b.blank = 1'b1;
        b.bar   = 1'($urandom_range(0, 1));
        name_beats = {name_beats, b};
    endfunction

    // Blank beats inside a name carry no byte and must not disturb the scan.
    function automatic void push_byte(input t_char c, input logic bar);
        t_beat b;
        if (scatter_blanks && $urandom_range(0, 9) == 0)
            push_blank();
        b.code  = c;
        b.last  = 1'b0;
        b.blank = 1'b0;
        b.bar   = bar;
        name_beats = {name_beats, b};
    endfunction

    function automatic t_char pick_word_char();
        t_char c;
        case ($urandom_range(0, 3))
            0:       c = CH_LC_A + t_char'($urandom_range(0, 25));
            1:       c = CH_UC_A + t_char'($urandom_range(0, 25));
            2:       c = CH_DIG_0 + t_char'($urandom_range(0, 9));
            default: c = CH_UNDER;
        endcase
        return c;
    endfunction

    function automatic t_char pick_symbol();
        return t_char'(sym_set[$urandom_range(0, sym_set.len() - 1)]);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input t_beat b);
        int gap;
        gap = tx_gappy ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_code  <= b.code;
        in_ch.is_last    <= b.last;
        in_ch.empty_name <= b.blank;
        in_ch.allow_bar  <= b.bar;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (!(b.blank && !b.last))
            beat_count++;
    endtask

    task automatic send_name(input bit close_blank);
        t_beat b;
        if (close_blank || name_beats.size() == 0) begin
            push_blank();
            name_beats[name_beats.size() - 1].last = 1'b1;
        end else begin
            name_beats[name_beats.size() - 1].last = 1'b1;
        end
        while (name_beats.size() > 0) begin
            b = name_beats.pop_front();
            send_beat(b);
        end
        name_count++;
    endtask

    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic make_random_name();
        int len;
        int k;
        int pos;
        k = $urandom_range(0, 9);
        case (k)
            0: begin
                case ($urandom_range(0, 3))
                    0: begin push_byte(CH_LBRACK, 1'b0); push_byte(CH_RBRACK, 1'b0); end
                    1: begin push_byte(CH_LBRACE, 1'b0); push_byte(CH_RBRACE, 1'b0); end
                    2: push_byte(CH_SEMI, 1'($urandom_range(0, 1)));
                    default: push_byte(CH_BANG, 1'($urandom_range(0, 1)));
                endcase
                if ($urandom_range(0, 3) == 0)
                    push_byte(t_char'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            1, 2, 3, 8: begin
                push_byte(CH_LC_A + t_char'($urandom_range(0, 25)), 1'($urandom_range(0, 1)));
                len = $urandom_range(0, 6);
                repeat (len) push_byte(pick_word_char(), 1'($urandom_range(0, 1)));
            end
            4, 5, 6: begin
                len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 6);
                repeat (len) push_byte(pick_symbol(), 1'($urandom_range(0, 3) != 0));
            end
            7: begin
                len = $urandom_range(1, 5);
                repeat (len) push_byte(t_char'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)));
            end
            default: begin
                len = $urandom_range(1, 4);
                repeat (len) push_byte(t_char'(mixed_set[$urandom_range(0,
                                       mixed_set.len() - 1)]), 1'($urandom_range(0, 1)));
            end
        endcase
        // Corrupt one byte of an otherwise well-formed word.
        if (k == 8) begin
            pos = $urandom_range(0, name_beats.size() - 1);
            if (!name_beats[pos].blank)
                name_beats[pos].code = t_char'($urandom_range(0, 255));
        end
    endtask

    // Receiver: a random stall before each verdict beat, or one long hold on request.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                stall = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_code  = '0;
        in_ch.is_last    = 1'b0;
        in_ch.empty_name = 1'b0;
        in_ch.allow_bar  = 1'b0;
        cycle_count      = 0;
        beat_count       = 0;
        name_count       = 0;
        tx_gappy         = 1'b1;
        scatter_blanks   = 1'b0;
        hold_req         = 1'b0;
        burst_left       = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed names: the four exact atoms, lone dot, words, bars, blanks, odd bytes.
        push_byte(CH_LBRACK, 1'b0); push_byte(CH_RBRACK, 1'b0); send_name(1'b0);
        push_byte(CH_LBRACE, 1'b1); push_byte(CH_RBRACE, 1'b1); send_name(1'b0);
        push_byte(CH_SEMI, 1'b0); send_name(1'b0);
        push_byte(CH_BANG, 1'b0); send_name(1'b0);
        push_byte(CH_DOT, 1'b1); send_name(1'b0);
        push_byte(CH_DOT, 1'b0); push_byte("\\", 1'b0); send_name(1'b0);
        push_byte(CH_LC_A, 1'b0); push_byte(CH_UNDER, 1'b0);
        push_byte(CH_UC_Z, 1'b0); push_byte(CH_DIG_9, 1'b0); send_name(1'b0);
        push_byte(CH_BAR, 1'b1); send_name(1'b0);
        push_byte("+", 1'b1); push_byte(CH_BAR, 1'b0); send_name(1'b0);
        send_name(1'b1);
        push_blank(); push_byte(CH_LC_Z, 1'b0); send_name(1'b1);
        push_byte(8'h00, 1'b1); send_name(1'b0);
        push_byte(8'hFF, 1'b1); send_name(1'b0);
        push_byte(CH_UC_A, 1'b0); send_name(1'b0);
        push_byte(CH_LBRACK, 1'b0); send_name(1'b0);
        pause_until_drained();

        scatter_blanks = 1'b1;
        while (beat_count < BEAT_TARGET) begin
            if (burst_left > 0) begin
                burst_left--;
                tx_gappy = 1'b0;
            end else begin
                tx_gappy = ($urandom_range(0, 3) != 0);
            end
            // Stream back to back while the receiver holds off, so the block backs up.
            if (name_count % 150 == 40) begin
                hold_req   = 1'b1;
                burst_left = 40;
            end
            if (name_count % 70 == 60)
                pause_until_drained();
            make_random_name();
            send_name($urandom_range(0, 5) == 0);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("atom_quote_need_classifier_unit test passed");
        end else begin
            $display("atom_quote_need_classifier_unit test failed");
        end
        $finish;
    end

endmodule
